// ----- hdl/kped_pkg.sv -----
// ----------------------------------------------------------------------------
// kped_pkg
// Types, constants and register layout shared by the key press event detector.
// ----------------------------------------------------------------------------
`default_nettype none

package kped_pkg;

   localparam int NUM_KEYS        = 4;
   localparam int KEY_WIDTH       = $clog2(NUM_KEYS);
   localparam int TICK_WIDTH      = 16;
   localparam int DEBOUNCE_WIDTH  = 8;
   localparam int PERIOD_WIDTH    = 16;
   localparam int COUNT_WIDTH     = 8;
   localparam int CODE_WIDTH      = 3;
   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int REQ_TDATA_WIDTH = 8;
   localparam int RSP_TDATA_WIDTH = 16;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DOWN = 2'd1,
      ST_UP   = 2'd2,
      ST_LONG = 2'd3
   } press_state_type;

   typedef enum logic [CODE_WIDTH-1:0] {
      EV_NONE       = 3'd0,
      EV_DOWN       = 3'd1,
      EV_UP         = 3'd2,
      EV_LONG_START = 3'd3,
      EV_LONG_HOLD  = 3'd4,
      EV_LONG_FREE  = 3'd5,
      EV_REPEAT     = 3'd6
   } event_code_type;

   typedef enum logic [2:0] {
      REG_DEBOUNCE    = 3'd0,
      REG_LONG_PRESS  = 3'd1,
      REG_HOLD_REPEAT = 3'd2,
      REG_CLICK_GAP   = 3'd3,
      REG_ACTIVE_HIGH = 3'd4,
      REG_ENABLE      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [DEBOUNCE_WIDTH-1:0] debounce_ticks;
      logic [PERIOD_WIDTH-1:0]   long_press_ticks;
      logic [PERIOD_WIDTH-1:0]   hold_repeat_ticks;
      logic [PERIOD_WIDTH-1:0]   click_gap_ticks;
      logic [NUM_KEYS-1:0]       active_high_mask;
      logic [NUM_KEYS-1:0]       enable_mask;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      debounce_ticks:    8'd2,
      long_press_ticks:  16'd100,
      hold_repeat_ticks: 16'd10,
      click_gap_ticks:   16'd20,
      active_high_mask:  4'd8,
      enable_mask:       4'd0
   };

endpackage

`default_nettype wire

// ----- hdl/kped_csr.sv -----
// ----------------------------------------------------------------------------
// kped_csr
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module kped_csr
   import kped_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready,
   output cfg_type                        cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_DEBOUNCE:    cfg_in.debounce_ticks    = csr_pwdata[DEBOUNCE_WIDTH-1:0];
            REG_LONG_PRESS:  cfg_in.long_press_ticks  = csr_pwdata[PERIOD_WIDTH-1:0];
            REG_HOLD_REPEAT: cfg_in.hold_repeat_ticks = csr_pwdata[PERIOD_WIDTH-1:0];
            REG_CLICK_GAP:   cfg_in.click_gap_ticks   = csr_pwdata[PERIOD_WIDTH-1:0];
            REG_ACTIVE_HIGH: cfg_in.active_high_mask  = csr_pwdata[NUM_KEYS-1:0];
            REG_ENABLE:      cfg_in.enable_mask       = csr_pwdata[NUM_KEYS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_DEBOUNCE:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.debounce_ticks);
         REG_LONG_PRESS:  csr_prdata = CSR_DATA_WIDTH'(cfg_ff.long_press_ticks);
         REG_HOLD_REPEAT: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.hold_repeat_ticks);
         REG_CLICK_GAP:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.click_gap_ticks);
         REG_ACTIVE_HIGH: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.active_high_mask);
         REG_ENABLE:      csr_prdata = CSR_DATA_WIDTH'(cfg_ff.enable_mask);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/kped_engine.sv -----
// ----------------------------------------------------------------------------
// kped_engine
// Per-key state (debounced level, tick counter, press machine, click count)
// and the read-modify-write update of the key named by the current scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

module kped_engine
   import kped_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfg_type                cfg,
   input  wire logic                   step_valid,
   input  wire logic [KEY_WIDTH-1:0]   step_key,
   input  wire logic                   step_raw,
   output event_code_type              step_event,
   output logic      [COUNT_WIDTH-1:0] step_count
);

   logic                   stable_ff [NUM_KEYS];
   logic [TICK_WIDTH-1:0]  tick_ff   [NUM_KEYS];
   press_state_type        state_ff  [NUM_KEYS];
   logic [COUNT_WIDTH-1:0] repeat_ff [NUM_KEYS];

   logic                   stable_in;
   logic [TICK_WIDTH-1:0]  tick_in;
   press_state_type        state_in;
   logic [COUNT_WIDTH-1:0] repeat_in;

   logic                   cur_stable;
   logic [TICK_WIDTH-1:0]  cur_tick;
   press_state_type        cur_state;
   logic [COUNT_WIDTH-1:0] cur_repeat;
   logic                   key_en;
   logic                   level;
   logic                   settled;
   logic [TICK_WIDTH-1:0]  tick_sat;

   assign cur_stable = stable_ff[step_key];
   assign cur_tick   = tick_ff[step_key];
   assign cur_state  = state_ff[step_key];
   assign cur_repeat = repeat_ff[step_key];
   assign key_en     = cfg.enable_mask[step_key];
   assign level      = cfg.active_high_mask[step_key] ? step_raw : ~step_raw;
   assign settled    = key_en & (level == cur_stable);
   assign tick_sat   = (cur_tick == '1) ? cur_tick : cur_tick + 1'b1;

   always_comb begin
      state_in = cur_state;
      if (settled) begin
         unique case (cur_state)
            ST_IDLE: begin
               if (level) state_in = ST_DOWN;
            end
            ST_DOWN: begin
               if (!level) state_in = ST_UP;
               else if (tick_sat >= cfg.long_press_ticks) state_in = ST_LONG;
            end
            ST_LONG: begin
               if (!level) state_in = ST_IDLE;
            end
            ST_UP: begin
               if (level) state_in = ST_DOWN;
               else if (tick_sat >= cfg.click_gap_ticks) state_in = ST_IDLE;
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_comb begin
      stable_in  = cur_stable;
      tick_in    = cur_tick;
      repeat_in  = cur_repeat;
      step_event = EV_NONE;
      if (key_en && !settled) begin
         if (tick_sat >= TICK_WIDTH'(cfg.debounce_ticks)) begin
            stable_in = level;
            tick_in   = '0;
         end else begin
            tick_in = tick_sat;
         end
      end else if (settled) begin
         unique case (cur_state)
            ST_IDLE: begin
               if (level) begin
                  tick_in    = '0;
                  repeat_in  = COUNT_WIDTH'(1);
                  step_event = EV_DOWN;
               end
            end
            ST_DOWN: begin
               if (!level) begin
                  tick_in = '0;
                  if (cur_repeat == COUNT_WIDTH'(1)) step_event = EV_UP;
               end else if (tick_sat >= cfg.long_press_ticks) begin
                  tick_in    = '0;
                  repeat_in  = '0;
                  step_event = EV_LONG_START;
               end else begin
                  tick_in = tick_sat;
               end
            end
            ST_LONG: begin
               if (!level) begin
                  tick_in    = '0;
                  repeat_in  = '0;
                  step_event = EV_LONG_FREE;
               end else if (tick_sat >= cfg.hold_repeat_ticks) begin
                  tick_in    = '0;
                  step_event = EV_LONG_HOLD;
               end else begin
                  tick_in = tick_sat;
               end
            end
            ST_UP: begin
               if (level) begin
                  tick_in = '0;
                  if (cur_repeat != '1) repeat_in = cur_repeat + 1'b1;
               end else if (tick_sat >= cfg.click_gap_ticks) begin
                  if (cur_repeat > COUNT_WIDTH'(1)) step_event = EV_REPEAT;
                  tick_in   = '0;
                  repeat_in = '0;
               end else begin
                  tick_in = tick_sat;
               end
            end
            default: begin
               tick_in = '0;
            end
         endcase
      end
   end

   assign step_count = repeat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            stable_ff[i] <= 1'b0;
            tick_ff[i]   <= '0;
            state_ff[i]  <= ST_IDLE;
            repeat_ff[i] <= '0;
         end
      end else if (step_valid) begin
         stable_ff[step_key] <= stable_in;
         tick_ff[step_key]   <= tick_in;
         state_ff[step_key]  <= state_in;
         repeat_ff[step_key] <= repeat_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/key_press_event_detector.sv -----
// ----------------------------------------------------------------------------
// key_press_event_detector
// Debounces scan ticks per key and reports press, release, long press and
// multi-click events, one result per scan tick.
// ----------------------------------------------------------------------------
// The block takes one scan tick per clock cycle while the output is not stalled
// and returns exactly one result for each, in order. A tick is held in an input
// register; once the output register can advance, the key's state is updated
// and the result lands in the output register, where it is held until taken.
// The rate of one tick per cycle rests on the read-modify-write of the addressed
// key's state registers being done as the tick leaves the input register, so
// ticks for the same key may follow back to back.
// Configuration must be written only while no tick is in flight.
`default_nettype none

module key_press_event_detector
   import kped_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // req_tdata: key_index [1:0], raw_level [2], zero fill above.
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // rsp_tdata: event_key [1:0], event_code [4:2], click_count [12:5], zero fill.
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                            csr_pready
);

   cfg_type                cfg;

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [KEY_WIDTH-1:0]   s1_key_ff;
   logic                   s1_raw_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [KEY_WIDTH-1:0]   rsp_key_ff;
   event_code_type         rsp_code_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;

   logic                   advance;
   logic                   s1_fire;
   logic                   req_fire;
   event_code_type         step_event;
   logic [COUNT_WIDTH-1:0] step_count;

   kped_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kped_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step_valid (s1_fire),
      .step_key   (s1_key_ff),
      .step_raw   (s1_raw_ff),
      .step_event (step_event),
      .step_count (step_count)
   );

   assign advance      = ~rsp_valid_ff | rsp_tready;
   assign s1_fire      = s1_valid_ff & advance;
   assign req_tready   = ~s1_valid_ff | advance;
   assign req_fire     = req_tvalid & req_tready;
   assign s1_valid_in  = req_tready ? req_fire : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_key_ff <= req_tdata[KEY_WIDTH-1:0];
         s1_raw_ff <= req_tdata[KEY_WIDTH];
      end
      if (s1_fire) begin
         rsp_key_ff   <= s1_key_ff;
         rsp_code_ff  <= step_event;
         rsp_count_ff <= step_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_code_ff, rsp_key_ff};

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_code_ff == EV_DOWN) |-> rsp_count_ff == COUNT_WIDTH'(1))
      else $error("Down event reported with a click count other than one.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_code_ff == EV_LONG_START || rsp_code_ff == EV_LONG_FREE ||
                        rsp_code_ff == EV_REPEAT)) |-> rsp_count_ff == '0)
      else $error("Run-ending event reported with a nonzero click count.");

   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !cfg.enable_mask[s1_key_ff]) |=> rsp_code_ff == EV_NONE)
      else $error("Disabled key produced an event.");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("Input stalled while the output register is empty.");

endmodule

`default_nettype wire

// ----- test/key_press_event_detector_tb.sv -----
// ----------------------------------------------------------------------------
// key_press_event_detector_tb
// Drives scan ticks into the key press event detector and checks every event
// against a cycle-free model of the per-key debounce and press machine. The
// checks cover the reset defaults, single, double and long presses, click
// count saturation, the widest thresholds, and random press patterns under
// several register settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_event_detector_tb;
   import kped_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [KEY_WIDTH-1:0]   key;
      event_code_type         code;
      logic [COUNT_WIDTH-1:0] clicks;
   } key_event_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0]  csr_paddr;
   logic [CSR_DATA_WIDTH-1:0]  csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0]  csr_prdata;
   logic                       csr_pready;

   cfg_type                    model_cfg;
   logic                       key_settled [NUM_KEYS];
   logic [TICK_WIDTH-1:0]      key_ticks   [NUM_KEYS];
   press_state_type            key_phase   [NUM_KEYS];
   logic [COUNT_WIDTH-1:0]     key_clicks  [NUM_KEYS];

   key_event_type              pending_events [$];
   int                         mismatch_count;
   int                         idle_cycles;
   int                         send_idle_pct;
   int                         stall_pct;

   key_press_event_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void bump_ticks(int k);
      if (key_ticks[k] != '1) begin
         key_ticks[k] = key_ticks[k] + 1'b1;
      end
   endfunction

   function automatic key_event_type predict_key_event(logic [KEY_WIDTH-1:0] k, logic raw);
      key_event_type ev;
      logic          pressed;
      ev.key    = k;
      ev.code   = EV_NONE;
      ev.clicks = key_clicks[k];
      if (!model_cfg.enable_mask[k]) begin
         return ev;
      end
      pressed = model_cfg.active_high_mask[k] ? raw : ~raw;
      if (pressed != key_settled[k]) begin
         bump_ticks(k);
         if (key_ticks[k] >= model_cfg.debounce_ticks) begin
            key_settled[k] = pressed;
            key_ticks[k]   = '0;
         end
      end else begin
         case (key_phase[k])
            ST_IDLE: begin
               if (pressed) begin
                  key_phase[k]  = ST_DOWN;
                  key_ticks[k]  = '0;
                  key_clicks[k] = 8'd1;
                  ev.code       = EV_DOWN;
               end
            end
            ST_DOWN: begin
               if (!pressed) begin
                  key_phase[k] = ST_UP;
                  key_ticks[k] = '0;
                  if (key_clicks[k] == 8'd1) begin
                     ev.code = EV_UP;
                  end
               end else begin
                  bump_ticks(k);
                  if (key_ticks[k] >= model_cfg.long_press_ticks) begin
                     key_phase[k]  = ST_LONG;
                     key_ticks[k]  = '0;
                     key_clicks[k] = '0;
                     ev.code       = EV_LONG_START;
                  end
               end
            end
            ST_LONG: begin
               if (!pressed) begin
                  key_phase[k]  = ST_IDLE;
                  key_ticks[k]  = '0;
                  key_clicks[k] = '0;
                  ev.code       = EV_LONG_FREE;
               end else begin
                  bump_ticks(k);
                  if (key_ticks[k] >= model_cfg.hold_repeat_ticks) begin
                     key_ticks[k] = '0;
                     ev.code      = EV_LONG_HOLD;
                  end
               end
            end
            default: begin
               if (pressed) begin
                  key_phase[k] = ST_DOWN;
                  key_ticks[k] = '0;
                  if (key_clicks[k] != 8'hFF) begin
                     key_clicks[k] = key_clicks[k] + 1'b1;
                  end
               end else begin
                  bump_ticks(k);
                  if (key_ticks[k] >= model_cfg.click_gap_ticks) begin
                     if (key_clicks[k] > 8'd1) begin
                        ev.code = EV_REPEAT;
                     end
                     key_phase[k]  = ST_IDLE;
                     key_ticks[k]  = '0;
                     key_clicks[k] = '0;
                  end
               end
            end
         endcase
      end
      ev.clicks = key_clicks[k];
      return ev;
   endfunction

   task automatic send_tick(logic [KEY_WIDTH-1:0] k, logic raw);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {5'b0, raw, k};
      do @(posedge clock); while (!req_tready);
      pending_events.push_back(predict_key_event(k, raw));
   endtask

   task automatic hold_key(int k, logic pressed, int count);
      repeat (count) begin
         send_tick(k[KEY_WIDTH-1:0], model_cfg.active_high_mask[k] ? pressed : ~pressed);
      end
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_events.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] stored;
      stored = '0;
      case (idx)
         REG_DEBOUNCE: begin
            model_cfg.debounce_ticks = value[DEBOUNCE_WIDTH-1:0];
            stored[DEBOUNCE_WIDTH-1:0] = value[DEBOUNCE_WIDTH-1:0];
         end
         REG_LONG_PRESS: begin
            model_cfg.long_press_ticks = value[PERIOD_WIDTH-1:0];
            stored[PERIOD_WIDTH-1:0] = value[PERIOD_WIDTH-1:0];
         end
         REG_HOLD_REPEAT: begin
            model_cfg.hold_repeat_ticks = value[PERIOD_WIDTH-1:0];
            stored[PERIOD_WIDTH-1:0] = value[PERIOD_WIDTH-1:0];
         end
         REG_CLICK_GAP: begin
            model_cfg.click_gap_ticks = value[PERIOD_WIDTH-1:0];
            stored[PERIOD_WIDTH-1:0] = value[PERIOD_WIDTH-1:0];
         end
         REG_ACTIVE_HIGH: begin
            model_cfg.active_high_mask = value[NUM_KEYS-1:0];
            stored[NUM_KEYS-1:0] = value[NUM_KEYS-1:0];
         end
         default: begin
            model_cfg.enable_mask = value[NUM_KEYS-1:0];
            stored[NUM_KEYS-1:0] = value[NUM_KEYS-1:0];
         end
      endcase
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== stored) begin
         $display("%0t: register %s read back expected %h actual %h",
                  $time, idx.name(), stored, csr_prdata);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_timing(int debounce, int long_press, int hold, int gap);
      csr_write(REG_DEBOUNCE, debounce);
      csr_write(REG_LONG_PRESS, long_press);
      csr_write(REG_HOLD_REPEAT, hold);
      csr_write(REG_CLICK_GAP, gap);
   endtask

   // Every key is scanned at both levels while all keys are still disabled.
   task automatic test_disabled_after_reset();
      for (int k = 0; k < NUM_KEYS; k++) begin
         send_tick(k[KEY_WIDTH-1:0], 1'b0);
         send_tick(k[KEY_WIDTH-1:0], 1'b1);
      end
      settle_block();
   endtask

   task automatic test_directed_events();
      set_timing(1, 3, 2, 2);
      csr_write(REG_ACTIVE_HIGH, 4'b0101);
      csr_write(REG_ENABLE, 4'hF);
      // A single click ends in idle without a repeat event.
      hold_key(0, 1'b1, 2);
      hold_key(0, 1'b0, 4);
      // A double click reports one repeat once the gap has passed.
      hold_key(1, 1'b1, 2);
      hold_key(1, 1'b0, 2);
      hold_key(1, 1'b1, 2);
      hold_key(1, 1'b0, 4);
      // A long press goes through start, two holds and the release.
      hold_key(2, 1'b1, 9);
      hold_key(2, 1'b0, 2);
      settle_block();
   endtask

   task automatic test_click_saturation();
      int idle_pct [4] = '{0, 46, 0, 10};
      int busy_pct [4] = '{0, 0, 46, 10};
      set_timing(1, 16'hFFFF, 1, 16'hFFFF);
      csr_write(REG_ENABLE, 4'b0010);
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_pct[p];
         stall_pct     = busy_pct[p];
         repeat (64) begin
            hold_key(1, 1'b1, 2);
            hold_key(1, 1'b0, 2);
         end
      end
      hold_key(0, 1'b1, 2);
      settle_block();
   endtask

   task automatic test_widest_thresholds();
      send_idle_pct = 0;
      stall_pct     = 0;
      set_timing(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      csr_write(REG_ACTIVE_HIGH, 4'hF);
      csr_write(REG_ENABLE, 4'b0001);
      hold_key(0, 1'b1, 255 + 2);
      settle_block();
   endtask

   task automatic test_random_traffic();
      int                   idle_pct [4] = '{0, 46, 0, 10};
      int                   busy_pct [4] = '{0, 0, 46, 10};
      logic                 seg_pressed [NUM_KEYS];
      int                   seg_left    [NUM_KEYS];
      int                   k;
      int                   span;
      logic                 raw;
      for (int i = 0; i < NUM_KEYS; i++) begin
         seg_pressed[i] = 1'b0;
         seg_left[i]    = 0;
      end
      for (int p = 0; p < 8; p++) begin
         send_idle_pct = idle_pct[p / 2];
         stall_pct     = busy_pct[p / 2];
         set_timing($urandom_range(1, 3), $urandom_range(1, 10), $urandom_range(1, 4),
                    $urandom_range(1, 6));
         case (p)
            0: csr_write(REG_ACTIVE_HIGH, 4'h0);
            1: csr_write(REG_ACTIVE_HIGH, 4'hF);
            default: csr_write(REG_ACTIVE_HIGH, $urandom_range(0, 15));
         endcase
         csr_write(REG_ENABLE, (p % 3 == 2) ? $urandom_range(0, 15) : 4'hF);
         repeat (10) begin
            k = $urandom_range(0, NUM_KEYS - 1);
            if (seg_left[k] == 0) begin
               seg_pressed[k] = ($urandom_range(99) < 85) ? ~seg_pressed[k] : seg_pressed[k];
               span = seg_pressed[k]
                    ? model_cfg.debounce_ticks + model_cfg.long_press_ticks
                      + 2 * model_cfg.hold_repeat_ticks + 2
                    : model_cfg.debounce_ticks + model_cfg.click_gap_ticks + 2;
               seg_left[k] = $urandom_range(1, span);
            end
            seg_left[k]--;
            if ($urandom_range(99) < 8) begin
               raw = 1'($urandom_range(0, 1));
            end else begin
               raw = model_cfg.active_high_mask[k] ? seg_pressed[k] : ~seg_pressed[k];
            end
            send_tick(k[KEY_WIDTH-1:0], raw);
         end
         settle_block();
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected event expected none actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            if (rsp_tdata[1:0] !== pending_events[0].key) begin
               $display("%0t: event_key expected %0d actual %0d",
                        $time, pending_events[0].key, rsp_tdata[1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[4:2] !== pending_events[0].code) begin
               $display("%0t: event_code expected %s actual %0d",
                        $time, pending_events[0].code.name(), rsp_tdata[4:2]);
               mismatch_count++;
            end
            if (rsp_tdata[12:5] !== pending_events[0].clicks) begin
               $display("%0t: click_count expected %0d actual %0d",
                        $time, pending_events[0].clicks, rsp_tdata[12:5]);
               mismatch_count++;
            end
            if (rsp_tdata[15:13] !== 3'b000) begin
               $display("%0t: tdata fill expected 0 actual %b", $time, rsp_tdata[15:13]);
               mismatch_count++;
            end
            void'(pending_events.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 2000) begin
         $display("%0t: watchdog expired with %0d events outstanding",
                  $time, pending_events.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count = 0;
      idle_cycles    = 0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      model_cfg.debounce_ticks    = 8'd2;
      model_cfg.long_press_ticks  = 16'd100;
      model_cfg.hold_repeat_ticks = 16'd10;
      model_cfg.click_gap_ticks   = 16'd20;
      model_cfg.active_high_mask  = 4'd8;
      model_cfg.enable_mask       = 4'd0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         key_settled[k] = 1'b0;
         key_ticks[k]   = '0;
         key_phase[k]   = ST_IDLE;
         key_clicks[k]  = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_disabled_after_reset();
      test_directed_events();
      test_click_saturation();
      test_widest_thresholds();
      test_random_traffic();

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/kped_pkg.sv
hdl/kped_csr.sv
hdl/kped_engine.sv
hdl/key_press_event_detector.sv
test/key_press_event_detector_tb.sv
